// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers; all sample on clk and stand down during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every rising clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lcmsr_pkg.sv =====
package lcmsr_pkg;

  // Port widths fixed by the interface
  localparam int WL_W     = 7;   // word length register
  localparam int POS_W    = 6;   // row and column index
  localparam int VAL_W    = 7;   // matrix entry
  localparam int LETTER_W = 5;   // letter code

  localparam int MAX_LEN_DEF  = 64;
  localparam int ALPHABET_DEF = 26;

  typedef enum logic [9:0] {
    S_LOAD   = 10'b00_0000_0001,
    S_RB_RD  = 10'b00_0000_0010,
    S_RB_CHK = 10'b00_0000_0100,
    S_RB_CP  = 10'b00_0000_1000,
    S_RB_NEW = 10'b00_0001_0000,
    S_CK_RD  = 10'b00_0010_0000,
    S_CK_CMP = 10'b00_0100_0000,
    S_EM_RD  = 10'b00_1000_0000,
    S_EM_OUT = 10'b01_0000_0000,
    S_FAIL   = 10'b10_0000_0000
  } state_t;

endpackage

// ===== hdl/lcp_matrix_string_rebuild.sv =====
// Rebuilds the smallest word over ALPHABET letters from its n-by-n longest-common-prefix
// matrix. Load: one entry per cycle while busy is low; the entry that brings the count
// of in-range transfers to n*n starts the run, and busy stays high until the last result
// is out. The run reads the prefix table through one sequencer that issues a read and
// tests the registered data in the next cycle; it rebuilds the word, then checks every
// entry against it, then gives out the letters in order. Results appear for one cycle on
// out_strobe and cannot be held off; a word that fails gives one result with
// out_word_valid low and out_last_letter high. Writing the length register while busy
// is low restarts the load count.
module lcp_matrix_string_rebuild
  import lcmsr_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [WL_W-1:0]     cfg_wr_data,
  input  logic                start,
  output logic                busy,
  input  logic [POS_W-1:0]    in_row_index,
  input  logic [POS_W-1:0]    in_col_index,
  input  logic [VAL_W-1:0]    in_entry_value,
  output logic                out_strobe,
  output logic [LETTER_W-1:0] out_letter_code,
  output logic                out_word_valid,
  output logic                out_last_letter
);

  `include "assert_macros.svh"

  localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int AW       = 2 * IDX_W;
  localparam int PT_DEPTH = 1 << AW;
  localparam int CNT_W    = $clog2(MAX_LEN * MAX_LEN + 1);
  localparam int SQ_W     = 2 * WL_W;

  // Storage
  logic [VAL_W-1:0]    pt_mem [PT_DEPTH];
  logic [LETTER_W-1:0] ws_mem [MAX_LEN];

  logic                pt_we;
  logic [AW-1:0]       pt_wa, pt_ra_a, pt_ra_b;
  logic [VAL_W-1:0]    pt_rd_a_r, pt_rd_b_r;
  logic                ws_we;
  logic [LETTER_W-1:0] ws_wd;
  logic [IDX_W-1:0]    ws_ra_a, ws_ra_b;
  logic [LETTER_W-1:0] ws_rd_a_r, ws_rd_b_r;

  // Control
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ALPHABET-1:0] used_r, used_nxt;
  logic [WL_W-1:0]     wlen_r, wlen_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  logic [LETTER_W-1:0] out_letter_r, out_letter_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_last_r, out_last_nxt;

  logic [WL_W-1:0]     n_len;
  logic [SQ_W-1:0]     n_sq, cnt_inc;
  logic [WL_W-1:0]     i_inc, j_inc;
  logic                i_last, j_last;
  logic                accept, in_range;
  logic                free_found;
  logic [LETTER_W-1:0] free_idx;
  logic [VAL_W:0]      expect_val;
  logic                entry_ok;

  // Effective length: zero acts as one, above MAX_LEN clamps
  always_comb begin
    priority if (wlen_r == '0) begin
      n_len = WL_W'(1);
    end else if (wlen_r > WL_W'(MAX_LEN)) begin
      n_len = WL_W'(MAX_LEN);
    end else begin
      n_len = wlen_r;
    end
  end

  assign n_sq    = SQ_W'(n_len) * SQ_W'(n_len);
  assign cnt_inc = SQ_W'(cnt_r) + SQ_W'(1);
  assign i_inc   = WL_W'(i_r) + WL_W'(1);
  assign j_inc   = WL_W'(j_r) + WL_W'(1);
  assign i_last  = (i_inc == n_len);
  assign j_last  = (j_inc == n_len);

  assign busy     = (state_r != S_LOAD);
  assign accept   = start && !busy;
  assign in_range = (WL_W'(in_row_index) < n_len) && (WL_W'(in_col_index) < n_len);

  // Smallest letter not yet taken
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = ALPHABET - 1; k >= 0; k--) begin
      if (!used_r[k]) begin
        free_found = 1'b1;
        free_idx   = LETTER_W'(k);
      end
    end
  end

  // Prefix rule for the entry under test
  always_comb begin
    if (ws_rd_a_r == ws_rd_b_r) begin
      if (!i_last && !j_last) begin
        expect_val = {1'b0, pt_rd_b_r} + (VAL_W + 1)'(1);
      end else begin
        expect_val = (VAL_W + 1)'(1);
      end
    end else begin
      expect_val = '0;
    end
  end
  assign entry_ok = ({1'b0, pt_rd_a_r} == expect_val);

  // Memory ports
  assign pt_we = accept && in_range;
  assign pt_wa = {in_row_index[IDX_W-1:0], in_col_index[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= in_entry_value;
    end
    pt_rd_a_r <= pt_mem[pt_ra_a];
    pt_rd_b_r <= pt_mem[pt_ra_b];
  end

  always_ff @(posedge clk) begin
    if (ws_we) begin
      ws_mem[i_r] <= ws_wd;
    end
    ws_rd_a_r <= ws_mem[ws_ra_a];
    ws_rd_b_r <= ws_mem[ws_ra_b];
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    used_nxt       = used_r;
    wlen_nxt       = wlen_r;
    out_strobe_nxt = 1'b0;
    out_letter_nxt = out_letter_r;
    out_valid_nxt  = out_valid_r;
    out_last_nxt   = out_last_r;
    pt_ra_a        = {i_r, j_r};
    pt_ra_b        = {i_r + IDX_W'(1), j_r + IDX_W'(1)};
    ws_ra_a        = i_r;
    ws_ra_b        = j_r;
    ws_we          = 1'b0;
    ws_wd          = free_idx;

    unique case (state_r)
      S_LOAD: begin
        if (cfg_wr_en) begin
          wlen_nxt = cfg_wr_data;
          cnt_nxt  = '0;
          used_nxt = '0;
        end else if (accept && in_range) begin
          if (cnt_inc == n_sq) begin
            cnt_nxt   = '0;
            used_nxt  = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_RB_RD;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
      end
      S_RB_RD: begin
        // Probe entry [j][i] for each earlier position j
        pt_ra_a = {j_r, i_r};
        if (j_r == i_r) begin
          state_nxt = S_RB_NEW;
        end else begin
          state_nxt = S_RB_CHK;
        end
      end
      S_RB_CHK: begin
        ws_ra_a = j_r;
        if (pt_rd_a_r != '0) begin
          state_nxt = S_RB_CP;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_RB_RD;
        end
      end
      S_RB_CP: begin
        ws_we = 1'b1;
        ws_wd = ws_rd_a_r;
        j_nxt = '0;
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_CK_RD;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_RB_RD;
        end
      end
      S_RB_NEW: begin
        if (free_found) begin
          ws_we    = 1'b1;
          used_nxt = used_r | (ALPHABET'(1) << free_idx);
          j_nxt    = '0;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = S_CK_RD;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_RB_RD;
          end
        end else begin
          state_nxt = S_FAIL;
        end
      end
      S_CK_RD: begin
        state_nxt = S_CK_CMP;
      end
      S_CK_CMP: begin
        if (!entry_ok) begin
          state_nxt = S_FAIL;
        end else if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = S_EM_RD;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_CK_RD;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_CK_RD;
        end
      end
      S_EM_RD: begin
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        out_strobe_nxt = 1'b1;
        out_letter_nxt = ws_rd_a_r;
        out_valid_nxt  = 1'b1;
        out_last_nxt   = i_last;
        if (i_last) begin
          used_nxt  = '0;
          state_nxt = S_LOAD;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_EM_RD;
        end
      end
      S_FAIL: begin
        out_strobe_nxt = 1'b1;
        out_letter_nxt = '0;
        out_valid_nxt  = 1'b0;
        out_last_nxt   = 1'b1;
        used_nxt       = '0;
        state_nxt      = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      i_r          <= '0;
      j_r          <= '0;
      cnt_r        <= '0;
      used_r       <= '0;
      wlen_r       <= WL_W'(1);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      cnt_r        <= cnt_nxt;
      used_r       <= used_nxt;
      wlen_r       <= wlen_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_letter_r <= out_letter_nxt;
    out_valid_r  <= out_valid_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_letter_code = out_letter_r;
  assign out_word_valid  = out_valid_r;
  assign out_last_letter = out_last_r;

  `ASSERT_ALWAYS(a_state_onehot, $onehot(state_r), "sequencer state lost one-hot coding")
  `ASSERT_SAME(a_mid_run_busy, out_strobe_r && !out_last_r, busy, "run ended before last letter")
  `ASSERT_NEXT(a_strobe_spaced, out_strobe_r, !out_strobe_r, "back-to-back result transfers")
  `ASSERT_SAME(a_load_count, !busy, SQ_W'(cnt_r) < n_sq, "load count reached n*n while idle")

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcmsr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int CELLS       = MAX_LEN_DEF * MAX_LEN_DEF;

  typedef struct packed {
    logic [LETTER_W-1:0] code;
    logic                ok;
    logic                last;
  } letter_rec_t;

  typedef enum int {RUN_CLEAN, RUN_CORRUPT, RUN_RANDOM, RUN_REPEAT} run_kind_t;

  class word_rebuild_check;
    logic [VAL_W-1:0]    prefix_mem [CELLS];
    bit                  loaded [CELLS];
    logic [LETTER_W-1:0] letters [MAX_LEN_DEF];
    logic [WL_W-1:0]     length_reg;
    int unsigned         taken;
    letter_rec_t         pending_letters [$];
    int unsigned         mismatches;

    function new();
      length_reg = 1;
      taken = 0;
      mismatches = 0;
      foreach (loaded[k]) begin
        loaded[k] = 1'b0;
        prefix_mem[k] = '0;
      end
    endfunction

    function int unsigned span();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_LEN_DEF) return MAX_LEN_DEF;
      return length_reg;
    endfunction

    function int unsigned at(input int unsigned r, input int unsigned c);
      return prefix_mem[r * MAX_LEN_DEF + c];
    endfunction

    function bit region_loaded(input int unsigned n);
      for (int unsigned r = 0; r < n; r++)
        for (int unsigned c = 0; c < n; c++)
          if (!loaded[r * MAX_LEN_DEF + c]) return 1'b0;
      return 1'b1;
    endfunction

    function void set_length(input logic [WL_W-1:0] v);
      length_reg = v;
      taken = 0;
    endfunction

    function void complain(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Greedy smallest word, then the full prefix-rule check.
    function bit rebuild_word(input int unsigned n);
      bit [ALPHABET_DEF-1:0] used;
      bit                    copied;
      bit                    found;
      int unsigned           want;
      used = '0;
      for (int unsigned i = 0; i < n; i++) begin
        copied = 1'b0;
        for (int unsigned j = 0; j < i && !copied; j++)
          if (at(j, i) != 0) begin
            letters[i] = letters[j];
            copied = 1'b1;
          end
        if (!copied) begin
          found = 1'b0;
          for (int k = 0; k < ALPHABET_DEF && !found; k++)
            if (!used[k]) begin
              letters[i] = LETTER_W'(k);
              used[k] = 1'b1;
              found = 1'b1;
            end
          if (!found) return 1'b0;
        end
      end
      for (int unsigned i = 0; i < n; i++)
        for (int unsigned j = 0; j < n; j++) begin
          if (letters[i] == letters[j])
            want = (i + 1 < n && j + 1 < n) ? 1 + at(i + 1, j + 1) : 1;
          else
            want = 0;
          if (at(i, j) != want) return 1'b0;
        end
      return 1'b1;
    endfunction

    function void take_entry(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                             input logic [VAL_W-1:0] v);
      int unsigned n;
      n = span();
      if (r >= n || c >= n) return;
      prefix_mem[r * MAX_LEN_DEF + c] = v;
      loaded[r * MAX_LEN_DEF + c] = 1'b1;
      taken = (taken + 1) & 13'h1FFF;
      if (taken < n * n) return;
      taken = 0;
      if (!rebuild_word(n))
        pending_letters.push_back('{code: '0, ok: 1'b0, last: 1'b1});
      else
        for (int unsigned i = 0; i < n; i++)
          pending_letters.push_back('{code: letters[i], ok: 1'b1, last: (i + 1 == n)});
    endfunction

    function void check_letter(input logic [LETTER_W-1:0] code, input logic ok,
                               input logic last);
      letter_rec_t want;
      if (pending_letters.size() == 0) begin
        complain($sformatf("unexpected result: code %0d valid %0b last %0b",
                           code, ok, last));
        return;
      end
      want = pending_letters.pop_front();
      if (code !== want.code || ok !== want.ok || last !== want.last)
        complain($sformatf("mismatch: expected code %0d valid %0b last %0b, got %0d %0b %0b",
                           want.code, want.ok, want.last, code, ok, last));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [WL_W-1:0]     cfg_wr_data;
  logic                start;
  logic                busy;
  logic [POS_W-1:0]    in_row_index;
  logic [POS_W-1:0]    in_col_index;
  logic [VAL_W-1:0]    in_entry_value;
  logic                out_strobe;
  logic [LETTER_W-1:0] out_letter_code;
  logic                out_word_valid;
  logic                out_last_letter;

  word_rebuild_check sb;
  int                labels [MAX_LEN_DEF];
  int                mat [MAX_LEN_DEF][MAX_LEN_DEF];
  int unsigned       entries_sent;
  int unsigned       cycles;
  bit                gaps_on;

  lcp_matrix_string_rebuild dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .start           (start),
    .busy            (busy),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_entry_value  (in_entry_value),
    .out_strobe      (out_strobe),
    .out_letter_code (out_letter_code),
    .out_word_valid  (out_word_valid),
    .out_last_letter (out_last_letter)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_letter(out_letter_code, out_word_valid, out_last_letter);
      if (cfg_wr_en) sb.set_length(cfg_wr_data);
      if (start && !busy) sb.take_entry(in_row_index, in_col_index, in_entry_value);
    end
  end

  task automatic pause(input int k);
    start <= 1'b0;
    repeat (k) @(posedge clk);
  endtask

  // Hold start until the transfer; leave it high for a following item.
  task automatic send_entry(input int r, input int c, input int v);
    start <= 1'b1;
    in_row_index <= POS_W'(r);
    in_col_index <= POS_W'(c);
    in_entry_value <= VAL_W'(v);
    do @(posedge clk); while (busy);
    if (gaps_on && $urandom_range(5) == 0) pause($urandom_range(1, 10));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_letters.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_length(input int v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= WL_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // k letters at random, or all distinct when k is zero; then derive the matrix.
  function automatic void spell_word(input int n, input int k);
    for (int i = 0; i < n; i++) labels[i] = (k == 0) ? i : $urandom_range(k - 1);
    for (int i = n - 1; i >= 0; i--)
      for (int j = n - 1; j >= 0; j--)
        if (labels[i] != labels[j]) mat[i][j] = 0;
        else mat[i][j] = (i + 1 < n && j + 1 < n) ? mat[i + 1][j + 1] + 1 : 1;
  endfunction

  task automatic send_matrix(input int n, input run_kind_t kind);
    int cells [$];
    int pick;
    int tmp;
    int bad;
    int r;
    int c;
    int v;
    cells = {};
    for (int i = 0; i < n * n; i++) cells.push_back((i / n) * MAX_LEN_DEF + (i % n));
    // Duplicates leave some cells holding what the previous load put there.
    if (kind == RUN_REPEAT)
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(n * n - 1);
        cells[pick] = cells[$urandom_range(n * n - 1)];
      end
    if ($urandom_range(2) == 0)
      for (int k = cells.size() - 1; k > 0; k--) begin
        pick = $urandom_range(k);
        tmp = cells[k];
        cells[k] = cells[pick];
        cells[pick] = tmp;
      end
    bad = (kind == RUN_CORRUPT) ? $urandom_range(n * n - 1) : -1;
    foreach (cells[k]) begin
      if (n < MAX_LEN_DEF && $urandom_range(11) == 0) begin
        r = $urandom_range(MAX_LEN_DEF - 1);
        c = $urandom_range(MAX_LEN_DEF - 1, n);
        if ($urandom_range(1)) begin
          tmp = r;
          r = c;
          c = tmp;
        end
        send_entry(r, c, $urandom_range(64));
      end
      r = cells[k] / MAX_LEN_DEF;
      c = cells[k] % MAX_LEN_DEF;
      v = mat[r][c];
      if (kind == RUN_RANDOM)
        v = ($urandom_range(7) == 0) ? $urandom_range(64) : $urandom_range(n);
      if (k == bad) v = $urandom_range(64);
      send_entry(r, c, v);
      entries_sent++;
    end
  endtask

  initial begin
    int        n;
    int        cur_n;
    int        roll;
    int        part;
    bit        force_write;
    run_kind_t kind;

    rst_n = 1'b0;
    start = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_row_index = '0;
    in_col_index = '0;
    in_entry_value = '0;
    entries_sent = 0;
    gaps_on = 1'b1;
    force_write = 1'b0;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Length 1 straight out of reset, then length 0 acting as 1.
    send_entry(0, 0, 1);
    write_length(0);
    send_entry(0, 0, 0);
    send_entry(63, 0, 64);
    send_entry(0, 63, 0);
    send_entry(0, 0, 64);
    send_entry(0, 0, 1);

    write_length(2);
    spell_word(2, 0);
    send_matrix(2, RUN_CLEAN);
    spell_word(2, 1);
    send_matrix(2, RUN_CLEAN);

    // Abandon a partial load; the rewrite restarts the count.
    write_length(3);
    send_entry(0, 0, 3);
    send_entry(2, 2, 1);
    write_length(3);
    labels = '{default: 0};
    labels[1] = 1;
    for (int i = 2; i >= 0; i--)
      for (int j = 2; j >= 0; j--)
        if (labels[i] != labels[j]) mat[i][j] = 0;
        else mat[i][j] = (i < 2 && j < 2) ? mat[i + 1][j + 1] + 1 : 1;
    send_matrix(3, RUN_CLEAN);
    send_matrix(3, RUN_CORRUPT);

    cur_n = 3;
    while (entries_sent < 260) begin
      roll = $urandom_range(99);
      if (roll < 80) n = $urandom_range(1, 6);
      else if (roll < 95) n = $urandom_range(7, 12);
      else n = $urandom_range(13, 20);
      // Keep the load within the item budget.
      while (n > 2 && n * n > 270 - entries_sent) n--;
      if (n != cur_n || force_write || $urandom_range(3) == 0) begin
        write_length((n == 1 && $urandom_range(1)) ? 0 : n);
        cur_n = n;
        force_write = 1'b0;
      end else if ($urandom_range(7) == 0) begin
        drain();
      end
      spell_word(n, $urandom_range(1, n));
      roll = $urandom_range(99);
      if (roll < 8 && n > 1) begin
        part = $urandom_range(1, n * n - 1);
        for (int k = 0; k < part; k++) begin
          send_entry(k / n, k % n, mat[k / n][k % n]);
          entries_sent++;
        end
        force_write = 1'b1;
      end else begin
        if (roll < 65) kind = RUN_CLEAN;
        else if (roll < 80) kind = RUN_CORRUPT;
        else if (roll < 90) kind = RUN_RANDOM;
        else kind = sb.region_loaded(n) ? RUN_REPEAT : RUN_CLEAN;
        send_matrix(n, kind);
      end
    end

    // A length above the largest size takes every index; abandon that load.
    write_length(127);
    send_entry(63, 63, 1);
    send_entry(40, 63, 0);
    send_entry(63, 12, 0);

    gaps_on = 1'b0;
    repeat (6) begin
      n = $urandom_range(2, 5);
      write_length(n);
      spell_word(n, $urandom_range(1, n));
      send_matrix(n, ($urandom_range(3) == 0) ? RUN_CORRUPT : RUN_CLEAN);
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_letters.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lcmsr_pkg.sv
hdl/lcp_matrix_string_rebuild.sv
sim/testbench.sv
